// ----- rtl/config_write_frame_builder_defines.svh -----
// Assertion macros for the frame builder. The clock and reset names are those of the top level.
`ifndef CONFIG_WRITE_FRAME_BUILDER_DEFINES_SVH
`define CONFIG_WRITE_FRAME_BUILDER_DEFINES_SVH

// Plain property, checked on every rising clock edge outside reset
`define CWFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define CWFB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication
`define CWFB_ASSERT_AFTER2(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ----- rtl/cwfb_pkg.sv -----
package cwfb_pkg;

  // Configuration store depth and step counter width
  localparam int unsigned CfgByteCount = 6;
  localparam int unsigned StepW        = 3;

  // Frame constants
  localparam logic [7:0]  CmdByte0Bcast   = 8'h00;
  localparam logic [7:0]  CmdByte1        = 8'h01;
  localparam logic [7:0]  CfgByte0Default = 8'hFF;
  localparam logic [14:0] PecSeed         = 15'd16;
  localparam logic [15:0] PecPoly         = 16'h4599;

  typedef enum logic [1:0] {
    MODE_RESEND    = 2'd0,
    MODE_DEFAULTS  = 2'd1,
    MODE_DISCHARGE = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_e;

  // Byte source of a microcode step
  typedef enum logic [2:0] {
    SRC_CMD0,
    SRC_CMD1,
    SRC_PEC_HI,
    SRC_PEC_LO,
    SRC_CFG
  } src_e;

  // Next-step control
  typedef enum logic [1:0] {
    NX_WAIT_IN,  // wait for a command transaction
    NX_SEQ,      // advance when the byte is emitted
    NX_LOOP,     // jump to target until the last stored byte, then advance
    NX_JUMP      // jump to target when the byte is emitted
  } nxt_e;

  typedef struct packed {
    src_e             src;
    logic             crc_upd;
    logic             crc_seed;
    logic             idx_clr;
    logic             idx_inc;
    logic             last;
    nxt_e             nxt;
    logic [StepW-1:0] target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   load;   // command taken: update store, capture command byte, seed CRC
    logic   fire;   // current step emits its byte
    uword_t uw;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic out_busy;
    logic idx_last;
  } stat_t;

  // Program addresses
  localparam logic [StepW-1:0] StepIdle = 3'd0;
  localparam logic [StepW-1:0] StepCfg  = 3'd5;

  // Bytewise CRC15 table
  typedef logic [14:0] pec_tab_t [256];

  function automatic pec_tab_t pec_table_build();
    pec_tab_t    tab;
    logic [15:0] r;
    for (int i = 0; i < 256; i++) begin
      r = 16'(i) << 7;
      for (int b = 0; b < 8; b++) begin
        r = r[14] ? ((r << 1) ^ PecPoly) : (r << 1);
      end
      tab[i] = r[14:0];
    end
    return tab;
  endfunction

  localparam pec_tab_t PecTable = pec_table_build();

  // Microcode ROM
  function automatic uword_t ucode_rom(logic [StepW-1:0] step);
    uword_t uw;
    uw = '0;
    case (step)
      3'd0: uw = '{SRC_CMD0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NX_WAIT_IN, StepIdle};
      3'd1: uw = '{SRC_CMD0,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NX_SEQ,     StepIdle};
      3'd2: uw = '{SRC_CMD1,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NX_SEQ,     StepIdle};
      3'd3: uw = '{SRC_PEC_HI, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NX_SEQ,     StepIdle};
      3'd4: uw = '{SRC_PEC_LO, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, NX_SEQ,     StepIdle};
      3'd5: uw = '{SRC_CFG,    1'b1, 1'b0, 1'b0, 1'b1, 1'b0, NX_LOOP,    StepCfg};
      3'd6: uw = '{SRC_PEC_HI, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NX_SEQ,     StepIdle};
      3'd7: uw = '{SRC_PEC_LO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, NX_JUMP,    StepIdle};
      default: uw = '0;
    endcase
    return uw;
  endfunction

endpackage

// ----- rtl/cwfb_in_if.sv -----
interface cwfb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        broadcast;
  logic [3:0]  chip_address;
  logic [11:0] discharge_cells;
  logic [3:0]  discharge_timeout;

  modport source (
    output valid, mode, broadcast, chip_address, discharge_cells, discharge_timeout,
    input  ready
  );
  modport sink (
    input  valid, mode, broadcast, chip_address, discharge_cells, discharge_timeout,
    output ready
  );
endinterface

// ----- rtl/cwfb_out_if.sv -----
interface cwfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, frame_byte, frame_last, input ready);
  modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

// ----- rtl/cwfb_useq.sv -----
module cwfb_useq
  import cwfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_mode_i,
  input  stat_t      stat_i,
  output logic       in_ready_o,
  output ctrl_t      ctrl_o
);

  logic [StepW-1:0] step_q, step_d;
  uword_t           uw;
  logic             load, fire;

  // Decode the current step
  always_comb begin
    uw         = ucode_rom(step_q);
    in_ready_o = (uw.nxt == NX_WAIT_IN);
    load       = in_valid_i && in_ready_o && (in_mode_i != MODE_UNUSED);
    fire       = (uw.nxt != NX_WAIT_IN) && !stat_i.out_busy;
  end

  // Next step
  always_comb begin
    step_d = step_q;
    case (uw.nxt)
      NX_WAIT_IN: if (load) begin
        step_d = step_q + 1'b1;
      end
      NX_SEQ: if (fire) begin
        step_d = step_q + 1'b1;
      end
      NX_LOOP: if (fire) begin
        step_d = stat_i.idx_last ? step_q + 1'b1 : uw.target;
      end
      NX_JUMP: if (fire) begin
        step_d = uw.target;
      end
      default: step_d = StepIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = '{load: load, fire: fire, uw: uw};

endmodule

// ----- rtl/cwfb_dpath.sv -----
module cwfb_dpath
  import cwfb_pkg::*;
#(
  parameter int unsigned CfgBytes = CfgByteCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic [1:0]  mode_i,
  input  logic        broadcast_i,
  input  logic [3:0]  chip_address_i,
  input  logic [11:0] discharge_cells_i,
  input  logic [3:0]  discharge_timeout_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o,
  output stat_t       stat_o
);

  localparam int unsigned IdxW     = $clog2(CfgBytes);
  localparam int unsigned BmpLoIdx = CfgBytes - 2;
  localparam int unsigned BmpHiIdx = CfgBytes - 1;

  logic [7:0]      cfg_q [CfgBytes];
  logic [7:0]      cmd0_q;
  logic [IdxW-1:0] idx_q;
  logic [14:0]     crc_q, crc_d;
  logic [15:0]     pec;
  logic [7:0]      byte_sel;
  logic            out_valid_q;
  logic [7:0]      byte_q;
  logic            last_q;

  assign pec = {crc_q, 1'b0};

  // Byte source mux
  always_comb begin
    case (ctrl_i.uw.src)
      SRC_CMD0:   byte_sel = cmd0_q;
      SRC_CMD1:   byte_sel = CmdByte1;
      SRC_PEC_HI: byte_sel = pec[15:8];
      SRC_PEC_LO: byte_sel = pec[7:0];
      SRC_CFG:    byte_sel = cfg_q[idx_q];
      default:    byte_sel = '0;
    endcase
  end

  // CRC15, one byte per step
  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.load || (ctrl_i.fire && ctrl_i.uw.crc_seed)) begin
      crc_d = PecSeed;
    end else if (ctrl_i.fire && ctrl_i.uw.crc_upd) begin
      crc_d = {crc_q[6:0], 8'h00} ^ PecTable[crc_q[14:7] ^ byte_sel];
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  // Command byte 0, captured with the command
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      if (broadcast_i || (mode_i == MODE_DEFAULTS)) begin
        cmd0_q <= CmdByte0Bcast;
      end else begin
        cmd0_q <= {1'b1, chip_address_i, 3'b000};
      end
    end
  end

  // Stored configuration bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CfgBytes; i++) begin
        cfg_q[i] <= (i == 0) ? CfgByte0Default : 8'h00;
      end
    end else if (ctrl_i.load) begin
      if (mode_i == MODE_DEFAULTS) begin
        for (int i = 0; i < CfgBytes; i++) begin
          cfg_q[i] <= (i == 0) ? CfgByte0Default : 8'h00;
        end
      end else if (mode_i == MODE_DISCHARGE) begin
        cfg_q[BmpLoIdx] <= discharge_cells_i[7:0];
        cfg_q[BmpHiIdx] <= {discharge_timeout_i, discharge_cells_i[11:8]};
      end
    end
  end

  // Store read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctrl_i.load || (ctrl_i.fire && ctrl_i.uw.idx_clr)) begin
      idx_q <= '0;
    end else if (ctrl_i.fire && ctrl_i.uw.idx_inc && !stat_o.idx_last) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      byte_q <= byte_sel;
      last_q <= ctrl_i.uw.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = byte_q;
  assign frame_last_o    = last_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign stat_o.idx_last = (idx_q == IdxW'(CfgBytes - 1));

endmodule

// ----- rtl/config_write_frame_builder.sv -----
// Channel   Dir  Role    Payload
// cmd_i     in   sink    mode, broadcast, chip_address, discharge_cells, discharge_timeout
// frame_o   out  source  frame_byte, frame_last
//
// A command is accepted, then twelve frame bytes follow, one per cycle while frame_o is ready,
// paced by the microcode step counter and the single output register.
// The next command is taken while the last byte still waits in the output register.
// A stall on frame_o holds the step counter; an unused mode is taken and dropped.
// Reset restores the power-up configuration bytes and returns the sequencer to idle.
`include "config_write_frame_builder_defines.svh"

module config_write_frame_builder
  import cwfb_pkg::*;
#(
  parameter int unsigned CFG_BYTE_COUNT = CfgByteCount
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cwfb_in_if.sink    cmd_i,
  cwfb_out_if.source frame_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Step counter and microcode ROM
  cwfb_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_mode_i  (cmd_i.mode),
    .stat_i     (stat),
    .in_ready_o (cmd_i.ready),
    .ctrl_o     (ctrl)
  );

  // Store, CRC and output register
  cwfb_dpath #(
    .CfgBytes (CFG_BYTE_COUNT)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .mode_i              (cmd_i.mode),
    .broadcast_i         (cmd_i.broadcast),
    .chip_address_i      (cmd_i.chip_address),
    .discharge_cells_i   (cmd_i.discharge_cells),
    .discharge_timeout_i (cmd_i.discharge_timeout),
    .out_ready_i         (frame_o.ready),
    .out_valid_o         (frame_o.valid),
    .frame_byte_o        (frame_o.frame_byte),
    .frame_last_o        (frame_o.frame_last),
    .stat_o              (stat)
  );

  // Commands are taken only between frames
  `CWFB_ASSERT_IMPL(a_ready_between_frames, cmd_i.ready,
      !frame_o.valid || frame_o.frame_last, "command ready in mid-frame")

  // An offered byte never carries unknown bits
  `CWFB_ASSERT_IMPL(a_payload_known, frame_o.valid,
      !$isunknown(frame_o.frame_byte) && !$isunknown(frame_o.frame_last),
      "unknown frame payload")

  // A valid command starts its frame promptly
  `CWFB_ASSERT_AFTER2(a_frame_starts,
      cmd_i.valid && cmd_i.ready && (cmd_i.mode != MODE_UNUSED),
      frame_o.valid, "frame did not start")

endmodule
